// ===== src/pts_pkg.sv =====
`default_nettype none
package pts_pkg;

  // table size and time width
  localparam int NUM_TIMERS = 16;
  localparam int TIME_BITS  = 40;
  localparam int MAX_FIRE   = 16;

  localparam int SLOT_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int FIRE_CNT_W = $clog2(MAX_FIRE + 1);
  localparam int ORDER_W    = 32;
  localparam int ADD_W      = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;

  localparam logic [TIME_BITS-1:0] MAX_TIME = '1;

  // item field widths
  localparam int CMD_W       = 2;
  localparam int SLOT_FIELD_W = 4;
  localparam int PERIOD_W    = 32;
  localparam int NOW_W       = 40;
  localparam int TOL_W       = 16;

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd500;

  typedef enum logic [CMD_W-1:0] {
    CMD_REG   = 2'd0,
    CMD_UNREG = 2'd1,
    CMD_SCAN  = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_RUNNING   = 1'b0,
    REG_TOLERANCE = 1'b1
  } reg_idx_t;

endpackage
`default_nettype wire

// ===== src/pts_if.sv =====
`default_nettype none
// command channel
interface pts_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [pts_pkg::CMD_W-1:0]         command;
  logic [pts_pkg::SLOT_FIELD_W-1:0]  timer_slot;
  logic [pts_pkg::PERIOD_W-1:0]      period_ms;
  logic [pts_pkg::NOW_W-1:0]         now_ms;

  modport source (output valid, command, timer_slot, period_ms, now_ms, input ready);
  modport sink   (input valid, command, timer_slot, period_ms, now_ms, output ready);
endinterface

// fired timer channel
interface pts_fire_if;
  logic                              valid;
  logic                              ready;
  logic [pts_pkg::SLOT_FIELD_W-1:0]  fired_slot;
  logic [pts_pkg::NOW_W-1:0]         due_time_ms;
  logic                              last_fire;

  modport source (output valid, fired_slot, due_time_ms, last_fire, input ready);
  modport sink   (input valid, fired_slot, due_time_ms, last_fire, output ready);
endinterface
`default_nettype wire

// ===== src/periodic_timer_scheduler.sv =====
`default_nettype none
// channel    dir  handshake     payload
// cmd_in     in   valid/ready   command, timer_slot, period_ms, now_ms
// fire_out   out  valid/ready   fired_slot, due_time_ms, last_fire
// apb        in   psel/penable  running (0x0), tolerance_ms (0x4)
//
// register passes through ST_ARM before the channel reopens; unregister and ignored items finish in the accept cycle
// scan sets its limit in ST_LIMIT, then one comparator walks the slot table one
//   entry per cycle in ST_PASS for each fired slot, each walk followed by ST_COMMIT
// a stall on fire_out holds ST_COMMIT until the output register frees
// reset is synchronous: all slots idle, running on, tolerance 500 ms
module periodic_timer_scheduler (
  input  wire logic                         clk,
  input  wire logic                         rst,
  pts_cmd_if.sink                           cmd_in,
  pts_fire_if.source                        fire_out,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pts_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [pts_pkg::DATA_W-1:0]   pwdata,
  output logic      [pts_pkg::DATA_W-1:0]   prdata,
  output logic                              pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARM,
    ST_LIMIT,
    ST_PASS,
    ST_COMMIT
  } state_t;

  state_t state;

  // configuration registers
  logic                           running;
  logic [pts_pkg::TOL_W-1:0]      tolerance_ms;

  // slot table
  logic [pts_pkg::NUM_TIMERS-1:0] slot_armed;
  logic [pts_pkg::TIME_BITS-1:0]  slot_deadline [pts_pkg::NUM_TIMERS];
  logic [pts_pkg::PERIOD_W-1:0]   slot_period   [pts_pkg::NUM_TIMERS];
  logic [pts_pkg::ORDER_W-1:0]    slot_order    [pts_pkg::NUM_TIMERS];
  logic [pts_pkg::ORDER_W-1:0]    insert_counter;

  // latched item
  logic [pts_pkg::SLOT_W-1:0]     slot_r;
  logic [pts_pkg::PERIOD_W-1:0]   period_r;
  logic [pts_pkg::TIME_BITS-1:0]  now_r;

  // scan state
  logic [pts_pkg::TIME_BITS-1:0]  limit;
  logic [pts_pkg::NUM_TIMERS-1:0] picked;
  logic [pts_pkg::SLOT_W-1:0]     k;
  logic                           found;
  logic [pts_pkg::SLOT_W-1:0]     best_idx;
  logic [pts_pkg::TIME_BITS-1:0]  best_dl;
  logic [pts_pkg::ORDER_W-1:0]    best_ord;
  logic [pts_pkg::PERIOD_W-1:0]   best_per;
  logic                           have_pend;
  logic [pts_pkg::SLOT_W-1:0]     pend_idx;
  logic [pts_pkg::TIME_BITS-1:0]  pend_dl;
  logic [pts_pkg::FIRE_CNT_W-1:0] fire_cnt;

  // output register
  logic                           out_valid;
  logic [pts_pkg::SLOT_W-1:0]     out_idx;
  logic [pts_pkg::TIME_BITS-1:0]  out_dl;
  logic                           out_last;

  // shared saturating adder
  logic [pts_pkg::ADD_W-1:0]      add_b;
  logic [pts_pkg::ADD_W-1:0]      add_sum;
  logic [pts_pkg::TIME_BITS-1:0]  sat_sum;

  always_comb begin
    unique case (state)
      ST_ARM:   add_b = pts_pkg::ADD_W'(period_r);
      ST_LIMIT: add_b = pts_pkg::ADD_W'(tolerance_ms);
      default:  add_b = pts_pkg::ADD_W'(best_per);
    endcase
  end

  assign add_sum = pts_pkg::ADD_W'(now_r) + add_b;
  assign sat_sum = (add_sum > pts_pkg::ADD_W'(pts_pkg::MAX_TIME)) ? pts_pkg::MAX_TIME :
                   pts_pkg::TIME_BITS'(add_sum);

  // shared comparator on the slot under the walk
  logic [pts_pkg::TIME_BITS-1:0]  dl_k;
  logic [pts_pkg::ORDER_W-1:0]    ord_k;
  logic                           elig;
  logic                           better;
  logic                           take_k;

  assign dl_k   = slot_deadline[k];
  assign ord_k  = slot_order[k];
  assign elig   = slot_armed[k] && !picked[k] && (dl_k <= limit);
  assign better = !found || (dl_k < best_dl) || ((dl_k == best_dl) && (ord_k < best_ord));
  assign take_k = (state == ST_PASS) && elig && better;

  // handshake and commit decisions
  logic                           in_acc;
  logic                           out_free;
  logic                           can_fire;
  logic                           do_fire;
  logic                           do_push;
  logic                           in_slot_ok;
  logic [pts_pkg::SLOT_W-1:0]     in_sidx;

  assign cmd_in.ready = (state == ST_IDLE);
  assign in_acc       = cmd_in.valid && cmd_in.ready;
  assign out_free     = !out_valid || fire_out.ready;
  assign can_fire     = found && (fire_cnt < pts_pkg::FIRE_CNT_W'(pts_pkg::MAX_FIRE));
  assign do_fire      = (state == ST_COMMIT) && can_fire && (!have_pend || out_free);
  assign do_push      = (state == ST_COMMIT) && have_pend && out_free;
  assign in_slot_ok   = 32'(cmd_in.timer_slot) < 32'(pts_pkg::NUM_TIMERS);
  assign in_sidx      = pts_pkg::SLOT_W'(cmd_in.timer_slot);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      slot_armed     <= '0;
      insert_counter <= '0;
      picked         <= '0;
      k              <= '0;
      found          <= 1'b0;
      have_pend      <= 1'b0;
      fire_cnt       <= '0;
      out_valid      <= 1'b0;
    end else begin
      // output register: load on push, clear once taken
      if (do_push) begin
        out_valid <= 1'b1;
      end else if (fire_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (pts_pkg::cmd_t'(cmd_in.command))
              pts_pkg::CMD_REG: begin
                if (in_slot_ok && !slot_armed[in_sidx]) begin
                  state <= ST_ARM;
                end
              end
              pts_pkg::CMD_UNREG: begin
                if (in_slot_ok) begin
                  slot_armed[in_sidx] <= 1'b0;
                end
              end
              pts_pkg::CMD_SCAN: begin
                if (running) begin
                  state <= ST_LIMIT;
                end
              end
              default: ;
            endcase
          end
        end
        ST_ARM: begin
          slot_armed[slot_r] <= 1'b1;
          insert_counter     <= insert_counter + 1'b1;
          state              <= ST_IDLE;
        end
        ST_LIMIT: begin
          picked    <= '0;
          k         <= '0;
          found     <= 1'b0;
          have_pend <= 1'b0;
          fire_cnt  <= '0;
          state     <= ST_PASS;
        end
        ST_PASS: begin
          if (take_k) begin
            found <= 1'b1;
          end
          if (k == pts_pkg::SLOT_W'(pts_pkg::NUM_TIMERS - 1)) begin
            k     <= '0;
            state <= ST_COMMIT;
          end else begin
            k <= k + 1'b1;
          end
        end
        ST_COMMIT: begin
          if (can_fire) begin
            if (do_fire) begin
              picked[best_idx] <= 1'b1;
              insert_counter   <= insert_counter + 1'b1;
              fire_cnt         <= fire_cnt + 1'b1;
              have_pend        <= 1'b1;
              found            <= 1'b0;
              state            <= ST_PASS;
            end
          end else if (!have_pend || out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers and slot table payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot_r   <= in_sidx;
      period_r <= cmd_in.period_ms;
      now_r    <= pts_pkg::TIME_BITS'(cmd_in.now_ms);
    end
    if (state == ST_ARM) begin
      slot_deadline[slot_r] <= sat_sum;
      slot_period[slot_r]   <= period_r;
      slot_order[slot_r]    <= insert_counter;
    end
    if (state == ST_LIMIT) begin
      limit <= sat_sum;
    end
    if (take_k) begin
      best_idx <= k;
      best_dl  <= dl_k;
      best_ord <= ord_k;
      best_per <= slot_period[k];
    end
    if (do_push) begin
      out_idx  <= pend_idx;
      out_dl   <= pend_dl;
      out_last <= !can_fire;
    end
    if (do_fire) begin
      pend_idx                <= best_idx;
      pend_dl                 <= best_dl;
      slot_deadline[best_idx] <= sat_sum;
      slot_order[best_idx]    <= insert_counter;
    end
  end

  assign fire_out.valid       = out_valid;
  assign fire_out.fired_slot  = pts_pkg::SLOT_FIELD_W'(out_idx);
  assign fire_out.due_time_ms = pts_pkg::NOW_W'(out_dl);
  assign fire_out.last_fire   = out_last;

  // configuration port
  logic               cfg_wr;
  pts_pkg::reg_idx_t  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = pts_pkg::reg_idx_t'(paddr[pts_pkg::ADDR_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      running      <= 1'b1;
      tolerance_ms <= pts_pkg::TOL_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        pts_pkg::REG_RUNNING:   running      <= pwdata[0];
        pts_pkg::REG_TOLERANCE: tolerance_ms <= pwdata[pts_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      pts_pkg::REG_RUNNING:   prdata = pts_pkg::DATA_W'(running);
      pts_pkg::REG_TOLERANCE: prdata = pts_pkg::DATA_W'(tolerance_ms);
      default:                prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/pts_checker.sv =====
`default_nettype none
module pts_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic [pts_pkg::CMD_W-1:0]          command,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [pts_pkg::SLOT_FIELD_W-1:0]   fired_slot,
  input wire logic [pts_pkg::NOW_W-1:0]          due_time_ms,
  input wire logic                               last_fire
);

  // a stalled fired item holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fired_slot) &&
    $stable(due_time_ms) && $stable(last_fire))
    else $error("fired item changed while stalled");

  // fired items only come out of scan work
  a_fire_in_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("fired item appeared while idle");

  // a scan with more items to come keeps the command channel closed
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_fire |-> !in_ready)
    else $error("command channel open in the middle of a scan");

  // unregister finishes in its accept cycle
  a_unreg_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (command == pts_pkg::CMD_UNREG) |=> in_ready)
    else $error("unregister held the command channel");

endmodule

bind periodic_timer_scheduler pts_checker u_pts_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (cmd_in.valid),
  .in_ready    (cmd_in.ready),
  .command     (cmd_in.command),
  .out_valid   (fire_out.valid),
  .out_ready   (fire_out.ready),
  .fired_slot  (fire_out.fired_slot),
  .due_time_ms (fire_out.due_time_ms),
  .last_fire   (fire_out.last_fire)
);
`default_nettype wire
